// ----- design/ckb_pkg.sv -----
// Package for the color-key bitmap blitter: request structs, key color,
// register indexes and the internal pixel job record. No dependencies.
package ckb_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SELECT = 3'd4;

  localparam logic [7:0] KEY_BLUE  = 8'hEF;
  localparam logic [7:0] KEY_GREEN = 8'h00;
  localparam logic [7:0] KEY_RED   = 8'hFF;

  // Screen column and row of a pixel; the row bound covers screens of up to 1024 rows.
  localparam int JOB_COL_W = 10;
  localparam int JOB_ROW_W = 10;

  localparam int ADDR_W = 19;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       image_start;
  } in_item_t;

  typedef struct packed {
    logic              target_screen;
    logic [ADDR_W-1:0] byte_address;
    logic [7:0]        blue;
    logic [7:0]        green;
    logic [7:0]        red;
    logic              last_write;
  } out_item_t;

  // One visible, non-key pixel: screens still to write and its place on screen.
  typedef struct packed {
    logic [1:0]           mask;
    logic [JOB_COL_W-1:0] col;
    logic [JOB_ROW_W-1:0] row;
    logic [7:0]           blue;
    logic [7:0]           green;
    logic [7:0]           red;
  } job_t;

endpackage

// ----- design/ckb_scan.sv -----
// Byte sequencer of the blitter: configuration registers, triple assembly,
// row and padding counters, key and clip test. Depends on ckb_pkg.
module ckb_scan #(
  parameter int SCREEN_ROWS = 240,
  parameter int SCREEN_COLS = 400
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ckb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ckb_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_fire_i,
  input  ckb_pkg::in_item_t                in_data_i,
  output logic                             job_valid_o,
  output ckb_pkg::job_t                    job_o
);
  import ckb_pkg::*;

  localparam logic [1:0] PH_BLUE  = 2'd0;
  localparam logic [1:0] PH_GREEN = 2'd1;
  localparam logic [1:0] PH_RED   = 2'd2;

  logic [8:0] width_q, width_d;
  logic [7:0] height_q, height_d;
  logic [8:0] ox_q, ox_d;
  logic [7:0] oy_q, oy_d;
  logic [1:0] tsel_q, tsel_d;
  logic [1:0] phase_q, phase_d;
  logic [7:0] blue_q, blue_d;
  logic [7:0] green_q, green_d;
  logic [8:0] count_q, count_d;
  logic [7:0] rows_q, rows_d;
  logic [1:0] pad_q, pad_d;

  logic [8:0] eff_w;
  logic [7:0] eff_h;
  logic [7:0] new_h;
  logic [1:0] phase_s;
  logic [8:0] count_s;
  logic [8:0] count_inc;
  logic [7:0] rows_s;
  logic [7:0] rows_dec;
  logic [1:0] pad_s;
  logic       eor;
  logic [JOB_COL_W-1:0] col;
  logic [8:0] down;
  logic       visible;
  logic       is_key;

  always_comb begin
    eff_w = (width_q == '0) ? 9'd1 : width_q;
    eff_h = (height_q == '0) ? 8'd1 : height_q;

    // Restart request takes effect before this byte is used.
    phase_s = in_data_i.image_start ? PH_BLUE : phase_q;
    count_s = in_data_i.image_start ? '0 : count_q;
    pad_s   = in_data_i.image_start ? '0 : pad_q;
    rows_s  = in_data_i.image_start ? eff_h : rows_q;

    col     = {1'b0, ox_q} + {1'b0, count_s};
    down    = {1'b0, oy_q} + {1'b0, rows_s};
    visible = (32'(col) < SCREEN_COLS) && (32'(down) <= SCREEN_ROWS);
    is_key  = (blue_q == KEY_BLUE) && (green_q == KEY_GREEN) &&
              (in_data_i.pixel_byte == KEY_RED);

    job_o.mask  = (!is_key && visible) ? tsel_q : 2'b00;
    job_o.col   = col;
    job_o.row   = JOB_ROW_W'(SCREEN_ROWS - 32'(down));
    job_o.blue  = blue_q;
    job_o.green = green_q;
    job_o.red   = in_data_i.pixel_byte;
    job_valid_o = 1'b0;

    width_d  = width_q;
    height_d = height_q;
    ox_d     = ox_q;
    oy_d     = oy_q;
    tsel_d   = tsel_q;
    phase_d  = phase_q;
    blue_d   = blue_q;
    green_d  = green_q;
    count_d  = count_q;
    rows_d   = rows_q;
    pad_d    = pad_q;
    eor      = 1'b0;
    count_inc = count_s + 9'd1;
    new_h    = eff_h;

    if (in_fire_i) begin
      phase_d = phase_s;
      count_d = count_s;
      pad_d   = pad_s;
      rows_d  = rows_s;
      if (pad_s != '0) begin
        // Skip padding; the last one closes the row.
        pad_d = pad_s - 2'd1;
        eor   = (pad_s == 2'd1);
      end else begin
        unique case (phase_s)
          PH_BLUE: begin
            blue_d  = in_data_i.pixel_byte;
            phase_d = PH_GREEN;
          end
          PH_GREEN: begin
            green_d = in_data_i.pixel_byte;
            phase_d = PH_RED;
          end
          PH_RED: begin
            phase_d     = PH_BLUE;
            job_valid_o = (job_o.mask != 2'b00);
            if (count_inc >= eff_w) begin
              count_d = '0;
              pad_d   = eff_w[1:0];
              eor     = (eff_w[1:0] == 2'b00);
            end else begin
              count_d = count_inc;
            end
          end
          default: begin
            phase_d = PH_BLUE;
          end
        endcase
      end
    end

    rows_dec = rows_d - 8'd1;
    if (eor) begin
      // Other counters are already at their restart values here.
      rows_d = (rows_dec == '0) ? eff_h : rows_dec;
    end

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH: begin
          width_d = cfg_data_i[8:0];
          phase_d = PH_BLUE;
          count_d = '0;
          pad_d   = '0;
          rows_d  = eff_h;
        end
        CFG_IMAGE_HEIGHT: begin
          height_d = cfg_data_i[7:0];
          new_h    = (cfg_data_i[7:0] == '0) ? 8'd1 : cfg_data_i[7:0];
          phase_d  = PH_BLUE;
          count_d  = '0;
          pad_d    = '0;
          rows_d   = new_h;
        end
        CFG_ORIGIN_X:      ox_d   = cfg_data_i[8:0];
        CFG_ORIGIN_Y:      oy_d   = cfg_data_i[7:0];
        CFG_TARGET_SELECT: tsel_d = cfg_data_i[1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd1;
      height_q <= 8'd1;
      ox_q     <= '0;
      oy_q     <= '0;
      tsel_q   <= 2'd1;
      phase_q  <= PH_BLUE;
      count_q  <= '0;
      rows_q   <= 8'd1;
      pad_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      ox_q     <= ox_d;
      oy_q     <= oy_d;
      tsel_q   <= tsel_d;
      phase_q  <= phase_d;
      count_q  <= count_d;
      rows_q   <= rows_d;
      pad_q    <= pad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blue_q  <= blue_d;
    green_q <= green_d;
  end

endmodule

// ----- design/color_key_bitmap_blitter.sv -----
// Top level of the color-key bitmap blitter: pixel job stage, address
// multiply and two-write output register. Depends on ckb_pkg and ckb_scan.
//
// The block takes the pixel array of a bottom-up 24-bit bitmap one byte per
// request, row padding included, and turns every blue, green, red triple that
// is not the key color (red FF, green 00, blue EF) and lies on screen into a
// framebuffer write: one for each selected screen, top screen first, with
// last_write on the final one. Byte requests are taken one per cycle without
// a gap while out_stall_i stays low; a pixel makes one write per selected
// screen, so only a pixel written to both screens needs a second write, and
// that is hidden by the two blank bytes of the next triple. The red byte goes
// into the job register, where the key and clip test have already been made,
// and from there through the constant multiply that forms the column-major
// address into the output register. Write configuration only while the block
// is idle; a write to the image width or height restarts the byte counters,
// as image_start does. There is no clearing pass after reset.
module color_key_bitmap_blitter #(
  parameter int SCREEN_ROWS = 240,
  parameter int SCREEN_COLS = 400
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ckb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ckb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ckb_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ckb_pkg::out_item_t             out_data_o
);
  import ckb_pkg::*;

  // Wide enough for column * rows + row, times three, at the largest screen.
  localparam int PROD_W = 24;

  logic  in_fire;
  logic  out_fire;
  logic  scan_valid;
  job_t  scan_job;

  logic  jv_q, jv_d;
  job_t  job_q;

  logic [1:0]        omask_q, omask_d;
  logic [ADDR_W-1:0] addr_q;
  logic [7:0]        blue_q, green_q, red_q;

  logic              out_last;
  logic              out_free;
  logic              load_out;
  logic [PROD_W-1:0] pix_index;
  logic [PROD_W-1:0] byte_off;

  ckb_scan #(
    .SCREEN_ROWS (SCREEN_ROWS),
    .SCREEN_COLS (SCREEN_COLS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_fire_i   (in_fire),
    .in_data_i   (in_data_i),
    .job_valid_o (scan_valid),
    .job_o       (scan_job)
  );

  // Output side: a write is pending for each set bit of the screen mask.
  assign out_valid_o = (omask_q != 2'b00);
  assign out_fire    = out_valid_o && !out_stall_i;
  assign out_last    = (omask_q != 2'b11);

  // Free the output register when it is empty or its last write leaves now.
  assign out_free  = !out_valid_o || (out_fire && out_last);
  assign load_out  = jv_q && out_free;

  // Take a byte whenever the job register is empty or drains this cycle.
  assign in_stall_o = jv_q && !load_out;
  assign in_fire    = in_valid_i && !in_stall_o;

  // Column-major address: (rows * column + row) * 3.
  assign pix_index = PROD_W'(job_q.col) * PROD_W'(SCREEN_ROWS) + PROD_W'(job_q.row);
  assign byte_off  = (pix_index << 1) + pix_index;

  always_comb begin
    jv_d = jv_q;
    if (in_fire) begin
      jv_d = scan_valid;
    end else if (load_out) begin
      jv_d = 1'b0;
    end

    omask_d = omask_q;
    if (load_out) begin
      omask_d = job_q.mask;
    end else if (out_fire) begin
      // Drop the screen just written; top screen goes first.
      omask_d = omask_q & (omask_q - 2'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jv_q    <= 1'b0;
      omask_q <= 2'b00;
    end else begin
      jv_q    <= jv_d;
      omask_q <= omask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && scan_valid) begin
      job_q <= scan_job;
    end
    if (load_out) begin
      addr_q  <= byte_off[ADDR_W-1:0];
      blue_q  <= job_q.blue;
      green_q <= job_q.green;
      red_q   <= job_q.red;
    end
  end

  always_comb begin
    out_data_o.target_screen = !omask_q[0];
    out_data_o.byte_address  = addr_q;
    out_data_o.blue          = blue_q;
    out_data_o.green         = green_q;
    out_data_o.red           = red_q;
    out_data_o.last_write    = out_last;
  end

  // A job never waits without a screen to write.
  a_job_has_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jv_q |-> (job_q.mask != 2'b00))
    else $error("job register holds a pixel with no target screen");

  // After a write that is not the last, the bottom-screen write follows.
  a_second_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !out_last) |=> (out_valid_o && out_data_o.target_screen))
    else $error("first of two writes not followed by bottom-screen write");

  // With the last write gone and nothing loaded, the output goes empty.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_last && !load_out) |=> !out_valid_o)
    else $error("output still valid after its last write left");

  // A blocked job stays put until the output register takes it.
  a_job_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (jv_q && !load_out) |=> (jv_q && $stable(job_q)))
    else $error("pending pixel job lost while output was busy");

endmodule

// ----- test/tb_color_key_bitmap_blitter.sv -----
// Self-checking testbench for color_key_bitmap_blitter: streams bitmap pixel
// bytes, predicts every framebuffer write and compares it field by field.
// Depends on ckb_pkg and the color_key_bitmap_blitter RTL only.
module tb_color_key_bitmap_blitter;
  timeunit 1ns;
  timeprecision 1ps;

  import ckb_pkg::*;

  localparam int SCREEN_ROWS = 240;
  localparam int SCREEN_COLS = 400;
  // Cycles without any accepted request or write before the run is declared hung.
  localparam int HANG_LIMIT  = 4000;
  // Cycles allowed for the job and multiply stages to empty out.
  localparam int DRAIN_CYCLES = 8;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;

  color_key_bitmap_blitter #(
    .SCREEN_ROWS(SCREEN_ROWS),
    .SCREEN_COLS(SCREEN_COLS)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hold reset at the start, then release it once for the whole run.
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ------------------------------------------------------------------------
  // Blitter predictor: its own copy of the registers and byte counters.
  // ------------------------------------------------------------------------
  logic [8:0] cfg_width;
  logic [7:0] cfg_height;
  logic [8:0] cfg_org_x;
  logic [7:0] cfg_org_y;
  logic [1:0] cfg_targets;

  logic [1:0] slot;        // which byte of the blue, green, red triple comes next
  logic [7:0] held_blue;
  logic [7:0] held_green;
  logic [8:0] column_cnt;
  logic [7:0] rows_left;   // counts bitmap rows down, bottom row first
  logic [1:0] pad_left;

  in_item_t  byte_reqs[$];        // requests waiting for the driver
  out_item_t pending_writes[$];   // framebuffer writes predicted, not yet seen

  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int bytes_queued = 0;
  int err_count = 0;
  int writes_seen = 0;
  int hang_cycles = 0;

  // A width or height of zero behaves as one.
  function automatic int eff_width();
    return (cfg_width == 0) ? 1 : int'(cfg_width);
  endfunction

  function automatic int eff_height();
    return (cfg_height == 0) ? 1 : int'(cfg_height);
  endfunction

  task automatic blit_restart();
    slot       = 2'd0;
    column_cnt = '0;
    pad_left   = 2'd0;
    rows_left  = 8'(eff_height());
  endtask

  task automatic row_done();
    rows_left = rows_left - 8'd1;
    // Last row of the image finished: start over for the next one.
    if (rows_left == 0) blit_restart();
  endtask

  task automatic blit_config(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_IMAGE_WIDTH: begin
        cfg_width = data[8:0];
        blit_restart();
      end
      CFG_IMAGE_HEIGHT: begin
        cfg_height = data[7:0];
        blit_restart();
      end
      CFG_ORIGIN_X:      cfg_org_x = data[8:0];
      CFG_ORIGIN_Y:      cfg_org_y = data[7:0];
      CFG_TARGET_SELECT: cfg_targets = data[1:0];
      default: ;
    endcase
  endtask

  // Advance the predictor by one accepted byte and queue the writes it causes.
  task automatic blit_step(input in_item_t req);
    int        col;
    int        down;
    int        addr;
    logic      is_key;
    logic      visible;
    out_item_t wr;
    if (req.image_start) blit_restart();
    if (pad_left != 0) begin
      // Padding bytes carry nothing; the last one closes the row.
      pad_left = pad_left - 2'd1;
      if (pad_left == 0) row_done();
    end else if (slot == 2'd0) begin
      held_blue = req.pixel_byte;
      slot      = 2'd1;
    end else if (slot == 2'd1) begin
      held_green = req.pixel_byte;
      slot       = 2'd2;
    end else begin
      slot    = 2'd0;
      col     = int'(cfg_org_x) + int'(column_cnt);
      down    = int'(cfg_org_y) + int'(rows_left);
      is_key  = (held_blue == KEY_BLUE) && (held_green == KEY_GREEN) &&
                (req.pixel_byte == KEY_RED);
      visible = (col < SCREEN_COLS) && (down <= SCREEN_ROWS);
      if (!is_key && visible) begin
        addr            = (SCREEN_ROWS * col + (SCREEN_ROWS - down)) * 3;
        wr.byte_address = ADDR_W'(addr);
        wr.blue         = held_blue;
        wr.green        = held_green;
        wr.red          = req.pixel_byte;
        // Top screen goes first; the bottom write, when selected, is always last.
        if (cfg_targets[0]) begin
          wr.target_screen = 1'b0;
          wr.last_write    = !cfg_targets[1];
          pending_writes.push_back(wr);
        end
        if (cfg_targets[1]) begin
          wr.target_screen = 1'b1;
          wr.last_write    = 1'b1;
          pending_writes.push_back(wr);
        end
      end
      column_cnt = column_cnt + 9'd1;
      if (int'(column_cnt) >= eff_width()) begin
        column_cnt = '0;
        pad_left   = 2'(eff_width() % 4);
        if (pad_left == 0) row_done();
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // Driver: present queued byte requests, idling at random between them.
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) blit_step(in_data);
      // Advance only when the current request is gone; a stalled one holds.
      if (!in_valid || !in_stall) begin
        if (byte_reqs.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
          in_data  <= byte_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Monitor: stall the write side at random and check every accepted write.
  // ------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    $display("[%0t] write %0d: %s", $realtime, writes_seen, what);
    err_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  out_item_t want_wr;

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < rcv_stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (pending_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected write %p", out_data));
      end else begin
        want_wr = pending_writes.pop_front();
        check_field("target_screen", out_data.target_screen, want_wr.target_screen);
        check_field("byte_address", out_data.byte_address, want_wr.byte_address);
        check_field("blue", out_data.blue, want_wr.blue);
        check_field("green", out_data.green, want_wr.green);
        check_field("red", out_data.red, want_wr.red);
        check_field("last_write", out_data.last_write, want_wr.last_write);
      end
      writes_seen++;
    end
  end

  // Watchdog: count cycles in which neither side moves anything.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      hang_cycles <= 0;
    end else begin
      hang_cycles <= hang_cycles + 1;
    end
    if (hang_cycles >= HANG_LIMIT) begin
      $display("[%0t] no progress for %0d cycles", $realtime, HANG_LIMIT);
      $display("tb_color_key_bitmap_blitter NOT OK");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] value, input logic start);
    in_item_t req;
    req.pixel_byte  = value;
    req.image_start = start;
    byte_reqs.push_back(req);
    bytes_queued++;
  endtask

  // Queue one pixel triple: key color, near misses of it, extremes or noise.
  task automatic push_pixel(input logic start);
    int         pick;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    pick = $urandom_range(99);
    b = 8'($urandom);
    g = 8'($urandom);
    r = 8'($urandom);
    if (pick < 40) begin
      b = KEY_BLUE;
      g = KEY_GREEN;
      r = KEY_RED;
      // Flip a single bit of one channel to land just beside the key.
      if (pick >= 25) begin
        case ($urandom_range(2))
          0:       b = b ^ (8'd1 << $urandom_range(7));
          1:       g = g ^ (8'd1 << $urandom_range(7));
          default: r = r ^ (8'd1 << $urandom_range(7));
        endcase
      end
    end else if (pick < 50) begin
      b = {8{1'($urandom_range(1))}};
      g = {8{1'($urandom_range(1))}};
      r = {8{1'($urandom_range(1))}};
    end
    push_byte(b, start);
    push_byte(g, 1'b0);
    push_byte(r, 1'b0);
  endtask

  // Queue a well-formed image, padding included; stop early at byte_limit.
  task automatic queue_image(input int w, input int h, input logic lead, input int byte_limit);
    int sent;
    int row;
    int col;
    int p;
    sent = 0;
    for (row = 0; row < h && sent < byte_limit; row++) begin
      for (col = 0; col < w && sent < byte_limit; col++) begin
        push_pixel(lead && sent == 0);
        sent += 3;
      end
      for (p = 0; p < w % 4 && sent < byte_limit; p++) begin
        push_byte(8'($urandom), 1'b0);
        sent++;
      end
    end
  endtask

  // Wait until every request is taken and every write has come out,
  // then let the pipeline settle before touching registers.
  task automatic wait_drained();
    do @(negedge clk);
    while (!(byte_reqs.size() == 0 && !in_valid && pending_writes.size() == 0));
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    blit_config(idx, data);
  endtask

  // Write all five registers; unused upper data bits are set now and then.
  task automatic apply_setting(input int w, input int h, input int ox, input int oy,
                               input int ts);
    logic [CFG_DATA_W-1:0] hi;
    logic [CFG_DATA_W-1:0] ts_junk;
    hi      = ($urandom_range(9) == 0) ? 9'h100 : 9'h000;
    ts_junk = ($urandom_range(9) == 0) ? (CFG_DATA_W'($urandom) & 9'h1FC) : 9'h000;
    cfg_write(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
    cfg_write(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h) | hi);
    cfg_write(CFG_ORIGIN_X, CFG_DATA_W'(ox));
    cfg_write(CFG_ORIGIN_Y, CFG_DATA_W'(oy) | hi);
    cfg_write(CFG_TARGET_SELECT, CFG_DATA_W'(ts) | ts_junk);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_edge_image(input int w, input int h, input int ox, input int oy,
                                input int ts);
    wait_drained();
    apply_setting(w, h, ox, oy, ts);
    queue_image((w == 0) ? 1 : w, (h == 0) ? 1 : h, 1'b1, 1 << 30);
  endtask

  initial begin : stimulus
    int   mode;
    int   mode_start;
    int   k;
    int   kind;
    int   w;
    int   h;
    int   ox;
    int   oy;
    int   ts;
    int   pick;
    logic force_start;

    // Predictor state after reset.
    cfg_width   = 9'd1;
    cfg_height  = 8'd1;
    cfg_org_x   = '0;
    cfg_org_y   = '0;
    cfg_targets = 2'd1;
    held_blue   = '0;
    held_green  = '0;
    blit_restart();
    force_start = 1'b0;

    wait (rst_n);

    for (mode = 0; mode < 3; mode++) begin
      wait_drained();
      case (mode)
        0: begin
          snd_idle_pct  = 16;
          rcv_stall_pct = 54;
        end
        1: begin
          snd_idle_pct  = 54;
          rcv_stall_pct = 16;
        end
        default: begin
          snd_idle_pct  = 0;
          rcv_stall_pct = 0;
        end
      endcase

      if (mode == 0) begin
        // Reset registers: one pixel per row, one padding byte, one row per image.
        // Key color: no write.
        push_byte(KEY_BLUE, 1'b1); push_byte(KEY_GREEN, 1'b0); push_byte(KEY_RED, 1'b0);
        push_byte(8'hFF, 1'b0);
        // All zero and all ones pixels both draw.
        push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        // One bit away from the key color: draws.
        push_byte(KEY_BLUE, 1'b0); push_byte(KEY_GREEN, 1'b0); push_byte(8'hFE, 1'b0);
        push_byte(8'h5A, 1'b0);
        // Restart in the middle of a triple: the third byte becomes blue.
        push_byte(8'h12, 1'b0); push_byte(8'h34, 1'b0);
        push_byte(8'h56, 1'b1); push_byte(8'h78, 1'b0); push_byte(8'h9A, 1'b0);
        push_byte(8'hA5, 1'b0);

        // Row up to the right edge on both screens; bottom-right corner;
        // last column and top row.
        run_edge_image(16, 1, 384, 0, 3);
        run_edge_image(1, 1, 399, 0, 1);
        run_edge_image(2, 1, 399, 239, 3);
      end else if (mode == 1) begin
        // Tall image reaching past the top; zero sizes; first row above the
        // screen, then address zero.
        run_edge_image(1, 12, 0, 232, 2);
        run_edge_image(0, 0, 0, 0, 3);
        run_edge_image(3, 2, 0, 239, 1);
      end else begin
        // No screen selected; a row of more than 256 pixels with one padding
        // byte, clipped right.
        run_edge_image(5, 3, 398, 238, 0);
        run_edge_image(257, 1, 300, 10, 3);
      end

      mode_start = bytes_queued;
      while (bytes_queued - mode_start < 100) begin
        pick = $urandom_range(99);
        if (pick < 5)       w = 0;
        else if (pick < 80) w = $urandom_range(1, 6);
        else                w = $urandom_range(7, 12);
        pick = $urandom_range(99);
        if (pick < 5)       h = 0;
        else if (w > 8)     h = 1;
        else if (pick < 85) h = $urandom_range(1, 3);
        else                h = $urandom_range(4, 6);
        pick = $urandom_range(99);
        if (pick < 50)      ox = $urandom_range(0, 20);
        else if (pick < 70) ox = $urandom_range(390, 399);
        else                ox = $urandom_range(0, 399);
        pick = $urandom_range(99);
        if (pick < 50)      oy = $urandom_range(0, 20);
        else if (pick < 70) oy = $urandom_range(225, 239);
        else                oy = $urandom_range(0, 239);
        pick = $urandom_range(99);
        if (pick < 5)       ts = 0;
        else if (pick < 30) ts = 1;
        else if (pick < 55) ts = 2;
        else                ts = 3;

        wait_drained();
        apply_setting(w, h, ox, oy, ts);
        if (w == 0) w = 1;
        if (h == 0) h = 1;

        for (k = $urandom_range(1, 3); k > 0; k--) begin
          kind = $urandom_range(99);
          if (kind < 78) begin
            queue_image(w, h, force_start || $urandom_range(1), 1 << 30);
            force_start = 1'b0;
          end else if (kind < 90) begin
            // Cut the image short; usually the next one restarts explicitly.
            queue_image(w, h, force_start || $urandom_range(1),
                        $urandom_range(1, w * h * 3));
            force_start = ($urandom_range(9) < 7);
          end else begin
            // Loose bytes with stray restarts.
            repeat ($urandom_range(1, 12)) push_byte(8'($urandom), ($urandom_range(7) == 0));
            force_start = ($urandom_range(9) < 7);
          end
        end
      end
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (pending_writes.size() != 0) begin
      report_mismatch($sformatf("%0d predicted writes never came", pending_writes.size()));
    end
    if (err_count == 0) begin
      $display("tb_color_key_bitmap_blitter OK");
    end else begin
      $display("tb_color_key_bitmap_blitter NOT OK");
    end
    $finish;
  end

endmodule
